>>> hdl/tsl_pkg.sv
package tsl_pkg;

  // pixels in one strip, and in one line buffer word
  localparam int STRIP_PIXELS = 8;
  localparam int WORD_W       = 64;

  // attribute bits
  localparam int ATTR_DEFER_BIT  = 15;
  localparam int ATTR_PAL_HI     = 14;
  localparam int ATTR_PAL_LO     = 13;
  localparam int ATTR_MIRROR_BIT = 11;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_DRAW   = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_READ   = 2'd3
  } tsl_action_t;

  // one strip, as drawn or as held in the deferred queue
  typedef struct packed {
    logic [31:0] pattern;
    logic [8:0]  x;
    logic        mirror;
    logic [1:0]  palette;
  } tsl_strip_t;

endpackage

>>> hdl/tile_strip_line_compositor.sv
// Scanline compositor for 8-pixel rows of 4-bit tile pattern data.
// Input channel (in_valid/in_ready) carries one item per transfer: clear,
// draw strip, commit deferred strips, or read pixel. Every item produces
// exactly one result transfer on out_valid/out_ready (pixel value for a
// read, overflow flag for a deferred draw that found the queue full).
// cfg_wr_en/cfg_wr_data set the background color used by clear; write it
// only while the block is idle.
// Steps per item; a new item is taken only once the last one is done:
//   draw or queue push: the execute state; read: the execute state, then
//   the data state, since the line memory read is registered; clear: a
//   fill sweep, which writes one word in each of the two line memory banks
//   per cycle; commit: one queue memory read and one strip write per cycle,
//   pipelined over the registered queue memory read
// The line buffer is two banks of 8-pixel words with byte enables, so a
// strip at any x lands in one word of each bank in a single write.
// After reset the block sweeps the line memory to zero with in_ready low;
// the deferred queue is empty.
// A result waits in the output register while out_ready is low; if another
// result finishes meanwhile it is parked and in_ready stays low.
module tile_strip_line_compositor
  import tsl_pkg::*;
#(
  parameter int LINE_PIXELS = 512,
  parameter int QUEUE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [8:0]  in_x_position,
  input  logic [31:0] in_pattern_row,
  input  logic [15:0] in_attribute,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_value,
  output logic        out_queue_overflow
);

  localparam int PIX_AW     = $clog2(LINE_PIXELS);
  localparam int BANK_AW    = PIX_AW - 4;
  localparam int BANK_WORDS = (LINE_PIXELS + 15) / 16;
  localparam int QAW        = $clog2(QUEUE_DEPTH);
  localparam int QCW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_FILL,
    ST_COMMIT,
    ST_HOLD
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               pend_r, pend_nxt;
  logic               fill_item_r, fill_item_nxt;
  logic [BANK_AW-1:0] fill_idx_r, fill_idx_nxt;
  logic [QCW-1:0]     cmt_idx_r, cmt_idx_nxt;
  logic [7:0]         fill_color_r, fill_color_nxt;
  logic [7:0]         bg_color_r, bg_color_nxt;

  // payload registers
  tsl_action_t        item_action_r, item_action_nxt;
  logic [8:0]         item_x_r, item_x_nxt;
  logic [31:0]        item_pattern_r, item_pattern_nxt;
  logic [15:0]        item_attr_r, item_attr_nxt;
  logic [7:0]         out_pixel_r, out_pixel_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic [7:0]         res_pixel_r, res_pixel_nxt;
  logic               res_ovf_r, res_ovf_nxt;

  // datapath
  tsl_strip_t                   item_strip;
  tsl_strip_t                   q_rd_strip;
  tsl_strip_t                   strip_src;
  logic [QCW-1:0]               q_count;
  logic                         q_full;
  logic                         q_push;
  logic                         q_clear;
  logic                         q_rd_en;
  logic                         strip_en;
  logic                         fill_en;
  logic                         mem_rd_en;
  logic [7:0]                   mem_rd_data;
  logic [1:0][BANK_AW-1:0]      place_addr;
  logic [1:0][WORD_W-1:0]       place_data;
  logic [1:0][STRIP_PIXELS-1:0] place_be;
  logic [1:0][BANK_AW-1:0]      mem_wr_addr;
  logic [1:0][WORD_W-1:0]       mem_wr_data;
  logic [1:0][STRIP_PIXELS-1:0] mem_wr_be;
  logic                         out_free;
  logic                         fin;
  logic [7:0]                   fin_pixel;
  logic                         fin_ovf;
  logic                         in_xfer;
  logic                         exec_draw;
  logic                         item_defer;

  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign item_defer = item_attr_r[ATTR_DEFER_BIT];
  assign exec_draw  = (state_r == ST_EXEC) && (item_action_r == ACT_DRAW);

  assign item_strip = '{pattern: item_pattern_r,
                        x:       item_x_r,
                        mirror:  item_attr_r[ATTR_MIRROR_BIT],
                        palette: item_attr_r[ATTR_PAL_HI:ATTR_PAL_LO]};

  // memory controls
  assign q_full    = (q_count >= QCW'(QUEUE_DEPTH));
  assign q_push    = exec_draw && item_defer && !q_full;
  assign q_clear   = (state_r == ST_EXEC) && (item_action_r == ACT_CLEAR);
  assign q_rd_en   = (state_r == ST_COMMIT) && (cmt_idx_r < q_count);
  assign strip_en  = (exec_draw && !item_defer) || pend_r;
  assign strip_src = pend_r ? q_rd_strip : item_strip;
  assign fill_en   = (state_r == ST_FILL);
  assign mem_rd_en = (state_r == ST_EXEC) && (item_action_r == ACT_READ);

  tsl_defer_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (q_clear),
    .push       (q_push),
    .push_strip (item_strip),
    .rd_en      (q_rd_en),
    .rd_idx     (cmt_idx_r[QAW-1:0]),
    .rd_strip   (q_rd_strip),
    .count      (q_count)
  );

  tsl_strip_place #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_place (
    .strip_en (strip_en),
    .strip    (strip_src),
    .wr_addr  (place_addr),
    .wr_data  (place_data),
    .wr_be    (place_be)
  );

  // fill sweep takes the write ports over from strip placement
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (fill_en) begin
        mem_wr_addr[b] = fill_idx_r;
        mem_wr_data[b] = {STRIP_PIXELS{fill_color_r}};
        mem_wr_be[b]   = '1;
      end else begin
        mem_wr_addr[b] = place_addr[b];
        mem_wr_data[b] = place_data[b];
        mem_wr_be[b]   = place_be[b];
      end
    end
  end

  tsl_line_mem #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_line (
    .clk     (clk),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .wr_be   (mem_wr_be),
    .rd_en   (mem_rd_en),
    .rd_addr (PIX_AW'(item_x_r)),
    .rd_data (mem_rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_pixel_nxt    = out_pixel_r;
    out_ovf_nxt      = out_ovf_r;
    res_pixel_nxt    = res_pixel_r;
    res_ovf_nxt      = res_ovf_r;
    pend_nxt         = q_rd_en;
    fill_item_nxt    = fill_item_r;
    fill_idx_nxt     = fill_idx_r;
    cmt_idx_nxt      = cmt_idx_r;
    fill_color_nxt   = fill_color_r;
    bg_color_nxt     = cfg_wr_en ? cfg_wr_data : bg_color_r;
    item_action_nxt  = item_action_r;
    item_x_nxt       = item_x_r;
    item_pattern_nxt = item_pattern_r;
    item_attr_nxt    = item_attr_r;
    fin              = 1'b0;
    fin_pixel        = 8'd0;
    fin_ovf          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          item_action_nxt  = tsl_action_t'(in_action);
          item_x_nxt       = in_x_position;
          item_pattern_nxt = in_pattern_row;
          item_attr_nxt    = in_attribute;
          state_nxt        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_action_r)
          ACT_CLEAR: begin
            fill_color_nxt = bg_color_r;
            fill_item_nxt  = 1'b1;
            fill_idx_nxt   = '0;
            state_nxt      = ST_FILL;
          end
          ACT_DRAW: begin
            fin     = 1'b1;
            fin_ovf = item_defer && q_full;
          end
          ACT_COMMIT: begin
            cmt_idx_nxt = '0;
            state_nxt   = ST_COMMIT;
          end
          ACT_READ: begin
            state_nxt = ST_RDATA;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RDATA: begin
        fin       = 1'b1;
        fin_pixel = (int'(item_x_r) < LINE_PIXELS) ? mem_rd_data : 8'd0;
      end
      ST_FILL: begin
        fill_idx_nxt = fill_idx_r + BANK_AW'(1);
        if (fill_idx_r == BANK_AW'(BANK_WORDS - 1)) begin
          if (fill_item_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COMMIT: begin
        // the strip read last cycle is still written in this one
        if (cmt_idx_r == q_count) begin
          fin = 1'b1;
        end else begin
          cmt_idx_nxt = cmt_idx_r + QCW'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = res_pixel_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result goes straight out, or is parked while the receiver stalls
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_pixel_nxt = fin_pixel;
        out_ovf_nxt   = fin_ovf;
        state_nxt     = ST_IDLE;
      end else begin
        res_pixel_nxt = fin_pixel;
        res_ovf_nxt   = fin_ovf;
        state_nxt     = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      fill_item_r  <= 1'b0;
      fill_idx_r   <= '0;
      cmt_idx_r    <= '0;
      fill_color_r <= 8'd0;
      bg_color_r   <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      fill_item_r  <= fill_item_nxt;
      fill_idx_r   <= fill_idx_nxt;
      cmt_idx_r    <= cmt_idx_nxt;
      fill_color_r <= fill_color_nxt;
      bg_color_r   <= bg_color_nxt;
    end
    item_action_r  <= item_action_nxt;
    item_x_r       <= item_x_nxt;
    item_pattern_r <= item_pattern_nxt;
    item_attr_r    <= item_attr_nxt;
    out_pixel_r    <= out_pixel_nxt;
    out_ovf_r      <= out_ovf_nxt;
    res_pixel_r    <= res_pixel_nxt;
    res_ovf_r      <= res_ovf_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pixel_value    = out_pixel_r;
  assign out_queue_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // queue never holds more strips than it has entries
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("deferred queue count beyond depth");

  // a parked result only exists while the output register is still full
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("parked result without a pending output");

  // fill sweep and strip writes never share the write ports
  a_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
    fill_en |-> !strip_en)
    else $error("strip write during fill sweep");

  // a push grows the queue by exactly one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (q_count == $past(q_count) + QCW'(1)))
    else $error("queue count did not follow push");
`endif

endmodule

>>> hdl/tsl_strip_place.sv
module tsl_strip_place
  import tsl_pkg::*;
#(
  parameter int LINE_PIXELS = 512
) (
  input  logic                                strip_en,
  input  tsl_strip_t                          strip,
  output logic [1:0][$clog2(LINE_PIXELS)-5:0] wr_addr,
  output logic [1:0][WORD_W-1:0]              wr_data,
  output logic [1:0][STRIP_PIXELS-1:0]        wr_be
);

  localparam int BANK_AW = $clog2(LINE_PIXELS) - 4;

  logic [STRIP_PIXELS-1:0][3:0] nib;
  logic [STRIP_PIXELS-1:0][9:0] pos;
  logic [WORD_W-1:0]            strip_data;
  logic [STRIP_PIXELS-1:0]      strip_be;
  logic [2*WORD_W-1:0]          win_data;
  logic [2*STRIP_PIXELS-1:0]    win_be;
  logic [5:0]                   word0;
  logic [5:0]                   addr_lo;
  logic [5:0]                   addr_hi;

  // pixel j lands at x + j
  always_comb begin
    for (int j = 0; j < STRIP_PIXELS; j++) begin
      nib[j] = strip.mirror ? strip.pattern[j*4 +: 4]
                            : strip.pattern[(STRIP_PIXELS-1-j)*4 +: 4];
      pos[j] = {1'b0, strip.x} + 10'(j);
      strip_data[j*8 +: 8] = {2'b00, strip.palette, nib[j]};
      strip_be[j] = strip_en && (nib[j] != 4'd0) && (int'(pos[j]) < LINE_PIXELS);
    end
  end

  // align to the word grid: low half goes to word0, high half to word0 + 1
  assign win_data = {{WORD_W{1'b0}}, strip_data} << {strip.x[2:0], 3'b000};
  assign win_be   = {{STRIP_PIXELS{1'b0}}, strip_be} << strip.x[2:0];
  assign word0    = strip.x[8:3];
  assign addr_lo  = {1'b0, word0[5:1]};
  assign addr_hi  = addr_lo + 6'd1;

  always_comb begin
    if (!word0[0]) begin
      wr_addr[0] = BANK_AW'(addr_lo);
      wr_data[0] = win_data[WORD_W-1:0];
      wr_be[0]   = win_be[STRIP_PIXELS-1:0];
      wr_addr[1] = BANK_AW'(addr_lo);
      wr_data[1] = win_data[2*WORD_W-1:WORD_W];
      wr_be[1]   = win_be[2*STRIP_PIXELS-1:STRIP_PIXELS];
    end else begin
      wr_addr[1] = BANK_AW'(addr_lo);
      wr_data[1] = win_data[WORD_W-1:0];
      wr_be[1]   = win_be[STRIP_PIXELS-1:0];
      wr_addr[0] = BANK_AW'(addr_hi);
      wr_data[0] = win_data[2*WORD_W-1:WORD_W];
      wr_be[0]   = win_be[2*STRIP_PIXELS-1:STRIP_PIXELS];
    end
  end

endmodule

>>> hdl/tsl_line_mem.sv
module tsl_line_mem
  import tsl_pkg::*;
#(
  parameter int LINE_PIXELS = 512
) (
  input  logic                                clk,
  input  logic [1:0][$clog2(LINE_PIXELS)-5:0] wr_addr,
  input  logic [1:0][WORD_W-1:0]              wr_data,
  input  logic [1:0][STRIP_PIXELS-1:0]        wr_be,
  input  logic                                rd_en,
  input  logic [$clog2(LINE_PIXELS)-1:0]      rd_addr,
  output logic [7:0]                          rd_data
);

  localparam int PIX_AW     = $clog2(LINE_PIXELS);
  localparam int BANK_AW    = PIX_AW - 4;
  localparam int BANK_WORDS = (LINE_PIXELS + 15) / 16;

  // even words in bank 0, odd words in bank 1
  logic [WORD_W-1:0] bank0_mem [BANK_WORDS];
  logic [WORD_W-1:0] bank1_mem [BANK_WORDS];

  logic [WORD_W-1:0] rd_word0_r;
  logic [WORD_W-1:0] rd_word1_r;
  logic              rd_bank_r;
  logic [2:0]        rd_byte_r;
  logic [WORD_W-1:0] rd_word;
  logic [BANK_AW-1:0] rd_waddr;

  assign rd_waddr = rd_addr[PIX_AW-1:4];

  always_ff @(posedge clk) begin
    for (int b = 0; b < STRIP_PIXELS; b++) begin
      if (wr_be[0][b]) begin
        bank0_mem[wr_addr[0]][b*8 +: 8] <= wr_data[0][b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < STRIP_PIXELS; b++) begin
      if (wr_be[1][b]) begin
        bank1_mem[wr_addr[1]][b*8 +: 8] <= wr_data[1][b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word0_r <= bank0_mem[rd_waddr];
      rd_word1_r <= bank1_mem[rd_waddr];
      rd_bank_r  <= rd_addr[3];
      rd_byte_r  <= rd_addr[2:0];
    end
  end

  assign rd_word = rd_bank_r ? rd_word1_r : rd_word0_r;
  assign rd_data = rd_word[{rd_byte_r, 3'b000} +: 8];

endmodule

>>> hdl/tsl_defer_queue.sv
module tsl_defer_queue
  import tsl_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clear,
  input  logic                               push,
  input  tsl_strip_t                         push_strip,
  input  logic                               rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]     rd_idx,
  output tsl_strip_t                         rd_strip,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  tsl_strip_t     queue_mem [QUEUE_DEPTH];
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (clear) begin
      count_nxt = '0;
    end else if (push) begin
      count_nxt = count_r + QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[count_r[QAW-1:0]] <= push_strip;
    end
    if (rd_en) begin
      rd_strip <= queue_mem[rd_idx];
    end
  end

  assign count = count_r;

endmodule

>>> dv/tile_strip_line_compositor_tb.sv
module tile_strip_line_compositor_tb
  import tsl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_PIXELS   = 512;
  localparam int QUEUE_DEPTH   = 128;
  // longest single item is a commit of a full queue, plus a clear pass
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + LINE_PIXELS / 16 + 16;
  localparam int MAX_REPORTS   = 10;
  localparam int DIRECTED_ROWS = 25;

  // one input transfer
  typedef struct packed {
    tsl_action_t action;
    logic [8:0]  x;
    logic [31:0] pattern;
    logic [15:0] attr;
  } strip_cmd_t;

  // one result transfer
  typedef struct packed {
    logic [7:0] pixel;
    logic       ovf;
  } line_result_t;

  // directed row: command plus an optional hand-written result
  typedef struct packed {
    tsl_action_t action;
    logic [8:0]  x;
    logic [31:0] pattern;
    logic [15:0] attr;
    logic        typed;
    logic [7:0]  pixel;
    logic        ovf;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_CLEAR;
  logic [8:0]  in_x_position = 9'd0;
  logic [31:0] in_pattern_row = 32'd0;
  logic [15:0] in_attribute = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_value;
  logic        out_queue_overflow;

  // shadow of the block: line image, deferred strips, background color
  logic [7:0]     line_img [LINE_PIXELS];
  tsl_strip_t     pending_strips [QUEUE_DEPTH];
  int             pending_cnt;
  logic [7:0]     bg_color;
  line_result_t   expected_results [$];

  int             errors;
  int             src_idle_pct;
  int             snk_idle_pct;
  logic [8:0]     last_x;
  directed_row_t  directed_rows [DIRECTED_ROWS];

  tile_strip_line_compositor #(
    .LINE_PIXELS(LINE_PIXELS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_x_position     (in_x_position),
    .in_pattern_row    (in_pattern_row),
    .in_attribute      (in_attribute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_queue_overflow(out_queue_overflow)
  );

  always #4 clk = ~clk;

  // paint one strip into the line image, zero nibbles see through
  function automatic void paint_strip(input tsl_strip_t s);
    logic [3:0] nib;
    int         pos;
    int         i;
    for (i = 0; i < STRIP_PIXELS; i++) begin
      nib = s.pattern[31 - 4 * i -: 4];
      pos = int'(s.x) + (s.mirror ? STRIP_PIXELS - 1 - i : i);
      if (nib != 4'd0 && pos < LINE_PIXELS) line_img[pos] = {2'b00, s.palette, nib};
    end
  endfunction

  // update the shadow state for one accepted command, return its result
  function automatic line_result_t composite_cmd(input strip_cmd_t c);
    line_result_t r;
    tsl_strip_t   s;
    int           i;
    r = '0;
    s.pattern = c.pattern;
    s.x       = c.x;
    s.mirror  = c.attr[ATTR_MIRROR_BIT];
    s.palette = c.attr[ATTR_PAL_HI:ATTR_PAL_LO];
    case (c.action)
      ACT_CLEAR: begin
        for (i = 0; i < LINE_PIXELS; i++) line_img[i] = bg_color;
        pending_cnt = 0;
      end
      ACT_DRAW: begin
        if (c.attr[ATTR_DEFER_BIT]) begin
          if (pending_cnt < QUEUE_DEPTH) begin
            pending_strips[pending_cnt] = s;
            pending_cnt++;
          end else begin
            // queue full: strip is lost and flagged
            r.ovf = 1'b1;
          end
        end else begin
          paint_strip(s);
        end
      end
      ACT_COMMIT: begin
        // queue is kept, a later commit paints the same strips again
        for (i = 0; i < pending_cnt; i++) paint_strip(pending_strips[i]);
      end
      default: begin
        if (int'(c.x) < LINE_PIXELS) r.pixel = line_img[c.x];
      end
    endcase
    return r;
  endfunction

  // random command of a given kind, fields cover every bit
  function automatic strip_cmd_t random_cmd(input tsl_action_t act, input bit defer);
    strip_cmd_t c;
    int         n;
    c.action  = act;
    c.x       = 9'($urandom_range(0, LINE_PIXELS - 1));
    c.pattern = $urandom;
    c.attr    = 16'($urandom_range(0, 16'hffff));
    if (act == ACT_DRAW) begin
      c.attr[ATTR_DEFER_BIT] = defer;
      // some transparent nibbles in most strips
      for (n = 0; n < STRIP_PIXELS; n++)
        if ($urandom_range(0, 3) == 0) c.pattern[4 * n +: 4] = 4'd0;
      // strips that run off the end of the line
      if ($urandom_range(0, 9) == 0) c.x = 9'($urandom_range(LINE_PIXELS - 8, LINE_PIXELS - 1));
    end
    // reads mostly land on or next to the last strip
    if (act == ACT_READ && $urandom_range(0, 9) < 7) c.x = last_x + 9'($urandom_range(0, 7));
    return c;
  endfunction

  // one input transfer, with a random idle gap in front of it
  task automatic send_cmd(input strip_cmd_t c, input bit typed, input line_result_t typed_res);
    int           gap;
    line_result_t r;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= c.action;
    in_x_position  <= c.x;
    in_pattern_row <= c.pattern;
    in_attribute   <= c.attr;
    do @(posedge clk); while (!in_ready);
    // transfer accepted at this edge
    r = composite_cmd(c);
    expected_results.push_back(typed ? typed_res : r);
    if (c.action == ACT_DRAW) last_x = c.x;
  endtask

  // background register write, only once the block has drained
  task automatic write_background(input logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bg_color  = value;
  endtask

  // one random phase: background write, optional queue fill, then a mix
  task automatic run_phase(input int n_items, input logic [7:0] bg, input int src_pct,
                           input int snk_pct, input bit fill_queue);
    int sent;
    int pick;
    int burst;
    int k;
    write_background(bg);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    if (fill_queue) begin
      // clear, push past the queue depth, then commit the full queue
      send_cmd(random_cmd(ACT_CLEAR, 1'b0), 1'b0, '0);
      burst = QUEUE_DEPTH + $urandom_range(1, 8);
      for (k = 0; k < burst; k++) send_cmd(random_cmd(ACT_DRAW, 1'b1), 1'b0, '0);
      send_cmd(random_cmd(ACT_COMMIT, 1'b0), 1'b0, '0);
      sent = burst + 2;
    end
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_cmd(random_cmd(ACT_CLEAR, 1'b0), 1'b0, '0);
      else if (pick < 55)
        send_cmd(random_cmd(ACT_DRAW, $urandom_range(0, 9) < 4), 1'b0, '0);
      else if (pick < 62)
        send_cmd(random_cmd(ACT_COMMIT, 1'b0), 1'b0, '0);
      else
        send_cmd(random_cmd(ACT_READ, 1'b0), 1'b0, '0);
      sent++;
    end
  endtask

  // receiver: random backpressure per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // result checker: every result transfer against the oldest expectation
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: pixel %02h overflow %0b",
                   out_pixel_value, out_queue_overflow);
      end else begin
        want = expected_results.pop_front();
        if (out_pixel_value !== want.pixel || out_queue_overflow !== want.ovf) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected pixel %02h overflow %0b, got pixel %02h overflow %0b",
                     want.pixel, want.ovf, out_pixel_value, out_queue_overflow);
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tile_strip_line_compositor test failed");
    $finish;
  end

  initial begin
    strip_cmd_t   c;
    line_result_t typed_res;
    int           i;

    errors       = 0;
    pending_cnt  = 0;
    bg_color     = 8'd0;
    last_x       = 9'd0;
    src_idle_pct = 9;
    snk_idle_pct = 80;
    for (i = 0; i < LINE_PIXELS; i++) line_img[i] = 8'd0;

    // action, x, pattern, attribute, typed, pixel, overflow
    directed_rows = '{
      // line is zero after reset, whatever the background register holds
      '{ACT_READ,   9'd0,   32'h00000000, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd511, 32'hffffffff, 16'hffff, 1'b1, 8'h00, 1'b0},
      '{ACT_CLEAR,  9'd0,   32'h00000000, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd511, 32'h00000000, 16'h0000, 1'b1, 8'hff, 1'b0},
      // plain strip at the left edge, palette zero
      '{ACT_DRAW,   9'd0,   32'h12345678, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd0,   32'h00000000, 16'h0000, 1'b1, 8'h01, 1'b0},
      // all ones at the right edge, palette three
      '{ACT_DRAW,   9'd504, 32'hffffffff, 16'h6000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd511, 32'h00000000, 16'h0000, 1'b1, 8'h3f, 1'b0},
      // mirrored strip hanging past the end of the line
      '{ACT_DRAW,   9'd510, 32'h9abcdef1, 16'h0800, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,   9'd511, 32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      // fully transparent strip leaves the background
      '{ACT_DRAW,   9'd100, 32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,   9'd100, 32'h00000000, 16'h0000, 1'b1, 8'hff, 1'b0},
      // deferred strip shows up only after commit
      '{ACT_DRAW,   9'd200, 32'h87654321, 16'ha000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd200, 32'h00000000, 16'h0000, 1'b1, 8'hff, 1'b0},
      '{ACT_COMMIT, 9'd0,   32'h00000000, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd200, 32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      // overwrite, then commit again repaints the queued strip
      '{ACT_DRAW,   9'd200, 32'h11111111, 16'h4000, 1'b0, 8'h00, 1'b0},
      '{ACT_COMMIT, 9'd0,   32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,   9'd201, 32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      // every attribute bit set: deferred, mirrored, palette three
      '{ACT_DRAW,   9'd511, 32'hffffffff, 16'hffff, 1'b0, 8'h00, 1'b0},
      '{ACT_COMMIT, 9'd0,   32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,   9'd511, 32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      // clear empties the queue, so the next commit paints nothing
      '{ACT_CLEAR,  9'd0,   32'h00000000, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{ACT_COMMIT, 9'd0,   32'h00000000, 16'h0000, 1'b1, 8'h00, 1'b0},
      '{ACT_READ,   9'd200, 32'h00000000, 16'h0000, 1'b1, 8'hff, 1'b0}
    };

    // synchronous reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with background at its top value
    write_background(8'hff);
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      c.action        = directed_rows[i].action;
      c.x             = directed_rows[i].x;
      c.pattern       = directed_rows[i].pattern;
      c.attr          = directed_rows[i].attr;
      typed_res.pixel = directed_rows[i].pixel;
      typed_res.ovf   = directed_rows[i].ovf;
      send_cmd(c, directed_rows[i].typed, typed_res);
    end

    // sender mostly busy, receiver mostly stalled, queue overflow burst
    run_phase(210, 8'h00, 9, 80, 1'b1);
    // sender mostly idle, receiver mostly ready
    run_phase(200, 8'($urandom_range(1, 254)), 80, 9, 1'b0);
    // no idling on either side
    run_phase(210, 8'($urandom_range(0, 255)), 0, 0, 1'b1);

    // drain, then watch for stray results
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tile_strip_line_compositor test passed");
    end else begin
      $display("tile_strip_line_compositor test failed");
    end
    $finish;
  end

endmodule
